[hw/rtl/msps_pkg.sv]
// msps_pkg: constants shared by the motor speed pid step block
// register indexes, field widths and reset values; no dependencies
package msps_pkg;

   // configuration port
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   localparam logic [CsrIdxW-1:0] CsrPGain     = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrIGain     = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrDGain     = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrMaxSpeed  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrOutLimit  = 3'd4;

   // field and state widths
   localparam int GainW   = 24;
   localparam int SpeedW  = 16;
   localparam int ErrW    = SpeedW + 1;
   localparam int DutyW   = 8;
   localparam int IntegW  = 40;
   localparam int ProdW   = GainW + 1 + ErrW;
   localparam int IntSumW = ProdW + 1;
   localparam int SumW    = ProdW + 2;
   localparam int FracW   = 16;

   // reset values of the configuration registers
   localparam logic [GainW-1:0]  PGainReset    = 24'd72090;
   localparam logic [GainW-1:0]  IGainReset    = 24'd0;
   localparam logic [GainW-1:0]  DGainReset    = 24'd0;
   localparam logic [SpeedW-1:0] MaxSpeedReset = 16'hFFFF;
   localparam logic [DutyW-1:0]  OutLimitReset = 8'd100;

   // lower saturation bound of the integral, -2^39 in the wider sum format
   localparam logic signed [IntSumW-1:0] IntegMin =
      -(IntSumW'(1) <<< (IntegW - 1));

endpackage

[hw/rtl/motor_speed_pid_step.sv]
// motor_speed_pid_step: pid speed loop, derivative on measurement, one tick per transaction
// depends on msps_pkg for register indexes, widths and reset values
//
// a request transaction is held in the input register and then in the result register;
// the input register moves on only when the result register is free or being taken;
// throughput: one transaction per cycle unless the result channel stalls; an active one
// updates the channel integral and previous speed at the same edge that loads the result.
// reset: synchronous, active high; clears valid flags and channel state, loads
// the register reset values.
module motor_speed_pid_step #(
   parameter int NUM_MOTORS = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] setpoint_rpm, [31:16] measured_rpm
   input  logic [0:0]  req_tuser,   // [0] motor_index
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] duty_percent, [24:8] speed_error, rest zero
   output logic [0:0]  rsp_tuser,   // [0] loop_active
   // configuration writes
   input  logic                         csr_we,
   input  logic [msps_pkg::CsrIdxW-1:0] csr_index,
   input  logic [msps_pkg::CsrDataW-1:0] csr_wdata
);

   // configuration registers
   logic [msps_pkg::GainW-1:0]  p_gain_ff,    p_gain_in;
   logic [msps_pkg::GainW-1:0]  i_gain_ff,    i_gain_in;
   logic [msps_pkg::GainW-1:0]  d_gain_ff,    d_gain_in;
   logic [msps_pkg::SpeedW-1:0] max_speed_ff, max_speed_in;
   logic [msps_pkg::DutyW-1:0]  out_limit_ff, out_limit_in;

   // input stage
   logic                        in_valid_ff,  in_valid_in;
   logic                        in_motor_ff,  in_motor_in;
   logic [msps_pkg::SpeedW-1:0] in_setpt_ff,  in_setpt_in;
   logic [msps_pkg::SpeedW-1:0] in_meas_ff,   in_meas_in;

   // result stage
   logic                              out_valid_ff, out_valid_in;
   logic [msps_pkg::DutyW-1:0]        out_duty_ff,  out_duty_in;
   logic signed [msps_pkg::ErrW-1:0]  out_err_ff,   out_err_in;
   logic                              out_active_ff, out_active_in;

   // per-channel state
   logic signed [msps_pkg::IntegW-1:0] integ_acc_ff [NUM_MOTORS];
   logic [msps_pkg::SpeedW-1:0]        prev_speed_ff [NUM_MOTORS];

   // datapath
   logic                                advance;
   logic                                chan_ok;
   logic                                active;
   logic signed [msps_pkg::IntegW-1:0]  acc_rd;
   logic [msps_pkg::SpeedW-1:0]         prev_rd;
   logic [msps_pkg::SpeedW-1:0]         meas_c;
   logic signed [msps_pkg::ErrW-1:0]    err;
   logic signed [msps_pkg::ErrW-1:0]    meas_diff;
   logic signed [msps_pkg::ProdW-1:0]   pterm;
   logic signed [msps_pkg::ProdW-1:0]   iterm;
   logic signed [msps_pkg::ProdW-1:0]   dterm;
   logic signed [msps_pkg::IntSumW-1:0] integ_sum;
   logic signed [msps_pkg::IntSumW-1:0] lim_q;
   logic signed [msps_pkg::IntegW-1:0]  integ_new;
   logic signed [msps_pkg::SumW-1:0]    sum;
   logic [msps_pkg::SumW-msps_pkg::FracW-1:0] sum_int;
   logic [msps_pkg::DutyW-1:0]          duty;

   // handshake: the input register moves on when the result register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_err_ff, out_duty_ff};
   assign rsp_tuser  = out_active_ff;

   // configuration write decode
   always_comb begin
      p_gain_in    = p_gain_ff;
      i_gain_in    = i_gain_ff;
      d_gain_in    = d_gain_ff;
      max_speed_in = max_speed_ff;
      out_limit_in = out_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            msps_pkg::CsrPGain:    p_gain_in    = csr_wdata;
            msps_pkg::CsrIGain:    i_gain_in    = csr_wdata;
            msps_pkg::CsrDGain:    d_gain_in    = csr_wdata;
            msps_pkg::CsrMaxSpeed: max_speed_in = csr_wdata[msps_pkg::SpeedW-1:0];
            msps_pkg::CsrOutLimit: out_limit_in = csr_wdata[msps_pkg::DutyW-1:0];
            default: ;
         endcase
      end
   end

   // input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      in_motor_in = in_motor_ff;
      in_setpt_in = in_setpt_ff;
      in_meas_in  = in_meas_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_motor_in = req_tuser[0];
         in_setpt_in = req_tdata[15:0];
         in_meas_in  = req_tdata[31:16];
      end
   end

   // channel state read
   always_comb begin
      acc_rd  = '0;
      prev_rd = '0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if (32'(in_motor_ff) == k) begin
            acc_rd  = integ_acc_ff[k];
            prev_rd = prev_speed_ff[k];
         end
      end
   end

   assign chan_ok = 32'(in_motor_ff) < NUM_MOTORS;
   assign active  = chan_ok && (in_setpt_ff != '0);

   // error and the three gain products
   assign meas_c    = (in_meas_ff > max_speed_ff) ? max_speed_ff : in_meas_ff;
   assign err       = $signed({1'b0, in_setpt_ff}) - $signed({1'b0, meas_c});
   assign meas_diff = $signed({1'b0, meas_c}) - $signed({1'b0, prev_rd});
   assign pterm     = $signed({1'b0, p_gain_ff}) * err;
   assign iterm     = $signed({1'b0, i_gain_ff}) * err;
   assign dterm     = $signed({1'b0, d_gain_ff}) * meas_diff;

   // integral update with clamp above at the limit and below at the register range
   assign integ_sum = msps_pkg::IntSumW'(acc_rd) + msps_pkg::IntSumW'(iterm);
   assign lim_q     = $signed({{(msps_pkg::IntSumW - msps_pkg::DutyW - msps_pkg::FracW){1'b0}},
                               out_limit_ff, {msps_pkg::FracW{1'b0}}});
   always_comb begin
      priority if (integ_sum > lim_q) begin
         integ_new = lim_q[msps_pkg::IntegW-1:0];
      end else if (integ_sum < msps_pkg::IntegMin) begin
         integ_new = msps_pkg::IntegMin[msps_pkg::IntegW-1:0];
      end else begin
         integ_new = integ_sum[msps_pkg::IntegW-1:0];
      end
   end

   // output sum, truncation and saturation to 0..limit
   assign sum     = msps_pkg::SumW'(pterm) + msps_pkg::SumW'(integ_new)
                    - msps_pkg::SumW'(dterm);
   assign sum_int = sum[msps_pkg::SumW-1:msps_pkg::FracW];
   always_comb begin
      priority if (sum <= 0) begin
         duty = '0;
      end else if (sum_int > (msps_pkg::SumW - msps_pkg::FracW)'(out_limit_ff)) begin
         duty = out_limit_ff;
      end else begin
         duty = sum_int[msps_pkg::DutyW-1:0];
      end
   end

   // result register load
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_duty_in   = out_duty_ff;
      out_err_in    = out_err_ff;
      out_active_in = out_active_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_duty_in   = active ? duty : '0;
         out_err_in    = active ? err  : '0;
         out_active_in = active;
      end else if (rsp_tready) begin
         out_valid_in  = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff    <= msps_pkg::PGainReset;
         i_gain_ff    <= msps_pkg::IGainReset;
         d_gain_ff    <= msps_pkg::DGainReset;
         max_speed_ff <= msps_pkg::MaxSpeedReset;
         out_limit_ff <= msps_pkg::OutLimitReset;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p_gain_ff    <= p_gain_in;
         i_gain_ff    <= i_gain_in;
         d_gain_ff    <= d_gain_in;
         max_speed_ff <= max_speed_in;
         out_limit_ff <= out_limit_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_motor_ff   <= in_motor_in;
      in_setpt_ff   <= in_setpt_in;
      in_meas_ff    <= in_meas_in;
      out_duty_ff   <= out_duty_in;
      out_err_ff    <= out_err_in;
      out_active_ff <= out_active_in;
   end

   // channel state update on an active transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_MOTORS; k++) begin
            integ_acc_ff[k]  <= '0;
            prev_speed_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_MOTORS; k++) begin
            if (advance && active && (32'(in_motor_ff) == k)) begin
               integ_acc_ff[k]  <= integ_new;
               prev_speed_ff[k] <= meas_c;
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   // an inactive result carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("inactive result with nonzero fields");

   // duty never exceeds the output limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] <= out_limit_ff))
      else $error("duty above output limit");

   // an inactive transaction leaves channel 0 state alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && !active) |=> ($stable(integ_acc_ff[0]) && $stable(prev_speed_ff[0])))
      else $error("state changed on an inactive transaction");
`endif

endmodule
